// ----- rtl/tsst_pkg.sv -----
`timescale 1ns / 1ps

package tsst_pkg;

	// TCP flag bits that the tracker looks at
	localparam logic [7:0] TCP_FIN   = 8'h01;
	localparam logic [7:0] TCP_SYN   = 8'h02;
	localparam logic [7:0] TCP_RST   = 8'h04;
	localparam logic [7:0] TCP_ACK   = 8'h10;
	localparam logic [7:0] FLAG_MASK = TCP_FIN | TCP_SYN | TCP_RST | TCP_ACK;

	localparam int SEQ_W = 32;
	localparam int LEN_W = 16;
	localparam int TS_W  = 48;
	localparam int RTT_W = 32;

	typedef enum logic [2:0] {
		ST_NONE        = 3'd0,
		ST_SYN_SENT    = 3'd1,
		ST_SYNACK_SENT = 3'd2,
		ST_ESTABLISHED = 3'd3,
		ST_CLOSING     = 3'd4,
		ST_CLOSED      = 3'd5
	} conn_state_t;

	typedef enum logic [1:0] {
		EV_NONE        = 2'd0,
		EV_ESTABLISHED = 2'd1,
		EV_CLOSED      = 2'd2
	} event_t;

	typedef struct packed {
		logic             side;
		logic [7:0]       flags;
		logic [SEQ_W-1:0] seq_num;
		logic [LEN_W-1:0] segment_length;
		logic [TS_W-1:0]  timestamp_us;
	} item_t;

	typedef struct packed {
		conn_state_t      session_state;
		event_t           event_res;
		logic             in_sequence;
		logic [SEQ_W-1:0] relative_seq;
		logic [RTT_W-1:0] handshake_rtt_us;
	} result_t;

	// only the low 32 bits of the SYN time ever reach the result
	typedef struct packed {
		logic                  seen_first;
		logic                  client_side;
		conn_state_t           conn_state;
		logic                  closer_side;
		logic [1:0]            has_base;
		logic [1:0][SEQ_W-1:0] base_seq;
		logic [1:0][SEQ_W-1:0] next_exp;
		logic [RTT_W-1:0]      syn_time;
	} state_t;

endpackage

// ----- rtl/tcp_session_state_tracker.sv -----
`timescale 1ns / 1ps

// Tracks one TCP session, one segment per transaction. A segment is taken
// into an input register, checked against the sender's expected sequence and
// stepped through the handshake/close state machine in combinational logic,
// and its result lands in an output register. One segment can be accepted
// every cycle while m_tready does not stall the output, since the whole
// compare-and-update on the session state is combinational. While a result
// waits on m_tready, one more segment can still be taken into the input register;
// after that s_tready follows m_tready.
// The first segment after reset decides which side is the client.
module tcp_session_state_tracker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // flags[7:0], seq_num[39:8], segment_length[55:40],
	                                // timestamp_us[103:56]
	input  logic         s_tuser,   // side
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata    // session_state[2:0], event_res[4:3], in_sequence[5],
	                                // relative_seq[37:6], handshake_rtt_us[69:38], zero[71:70]
);

	logic              valid_s1;
	tsst_pkg::item_t   item_s1;
	tsst_pkg::state_t  state_q;
	tsst_pkg::state_t  state_nxt;
	tsst_pkg::result_t res_nxt;
	tsst_pkg::result_t res_q;
	logic              out_free;
	logic              step;

	assign out_free = !m_tvalid || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.side           <= s_tuser;
			item_s1.flags          <= s_tdata[7:0];
			item_s1.seq_num        <= s_tdata[39:8];
			item_s1.segment_length <= s_tdata[55:40];
			item_s1.timestamp_us   <= s_tdata[103:56];
		end
	end

	tsst_update u_update (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{conn_state: tsst_pkg::ST_NONE, default: '0};
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_nxt;
		end
	end

	assign m_tdata = {2'b00, res_q.handshake_rtt_us, res_q.relative_seq, res_q.in_sequence,
		res_q.event_res, res_q.session_state};

endmodule

// ----- rtl/tsst_update.sv -----
`timescale 1ns / 1ps

module tsst_update (
	input  tsst_pkg::state_t  cur,
	input  tsst_pkg::item_t   item,
	output tsst_pkg::state_t  nxt,
	output tsst_pkg::result_t res
);

	logic                       client;
	logic                       from_client;
	logic [7:0]                 fl;
	logic [tsst_pkg::SEQ_W-1:0] rel;
	logic [tsst_pkg::SEQ_W-1:0] ne_adv;
	logic [tsst_pkg::SEQ_W-1:0] ne_base;
	logic                       ok;
	tsst_pkg::conn_state_t      st_nxt;

	always_comb begin
		client      = cur.seen_first ? cur.client_side : item.side;
		from_client = (item.side == client);
		fl          = item.flags & tsst_pkg::FLAG_MASK;
		rel         = item.seq_num - cur.base_seq[item.side];
		ok          = !cur.has_base[item.side] || (cur.next_exp[item.side] == rel);
		ne_adv      = cur.has_base[item.side]
			? cur.next_exp[item.side] + tsst_pkg::SEQ_W'(item.segment_length)
			: cur.next_exp[item.side];
		ne_base     = tsst_pkg::SEQ_W'(item.segment_length) + tsst_pkg::SEQ_W'(1);
	end

	// session state machine, next state
	always_comb begin
		st_nxt = cur.conn_state;
		if (ok) begin
			case (cur.conn_state)
				tsst_pkg::ST_NONE: begin
					if (fl == tsst_pkg::TCP_SYN && from_client)
						st_nxt = tsst_pkg::ST_SYN_SENT;
				end
				tsst_pkg::ST_SYN_SENT: begin
					if (fl == (tsst_pkg::TCP_SYN | tsst_pkg::TCP_ACK) && !from_client)
						st_nxt = tsst_pkg::ST_SYNACK_SENT;
				end
				tsst_pkg::ST_SYNACK_SENT: begin
					if (fl == tsst_pkg::TCP_ACK && from_client)
						st_nxt = tsst_pkg::ST_ESTABLISHED;
				end
				tsst_pkg::ST_ESTABLISHED: begin
					if ((fl & tsst_pkg::TCP_FIN) != 8'd0)
						st_nxt = tsst_pkg::ST_CLOSING;
				end
				tsst_pkg::ST_CLOSING: begin
					if ((fl & tsst_pkg::TCP_FIN) != 8'd0 && cur.closer_side != item.side)
						st_nxt = tsst_pkg::ST_CLOSED;
				end
				default: st_nxt = cur.conn_state;
			endcase
		end
	end

	// side effects of each transition on the per-side sequence tracking
	always_comb begin
		nxt             = cur;
		nxt.seen_first  = 1'b1;
		nxt.client_side = client;
		if (ok) begin
			nxt.next_exp[item.side] = ne_adv;
			nxt.conn_state          = st_nxt;
			if (st_nxt != cur.conn_state) begin
				case (st_nxt)
					tsst_pkg::ST_SYN_SENT: begin
						nxt.syn_time            = item.timestamp_us[tsst_pkg::RTT_W-1:0];
						nxt.has_base[item.side] = 1'b1;
						nxt.base_seq[item.side] = item.seq_num;
						nxt.next_exp[item.side] = ne_base;
					end
					tsst_pkg::ST_SYNACK_SENT: begin
						nxt.has_base[item.side] = 1'b1;
						nxt.base_seq[item.side] = item.seq_num;
						nxt.next_exp[item.side] = ne_base;
					end
					tsst_pkg::ST_CLOSING: begin
						// FIN takes one sequence number
						nxt.closer_side         = item.side;
						nxt.next_exp[item.side] = ne_adv + tsst_pkg::SEQ_W'(1);
					end
					tsst_pkg::ST_CLOSED: begin
						nxt.next_exp[item.side] = ne_adv + tsst_pkg::SEQ_W'(1);
					end
					default: nxt.conn_state = st_nxt;
				endcase
			end
		end
	end

	// session state machine, outputs
	always_comb begin
		res.session_state    = st_nxt;
		res.event_res        = tsst_pkg::EV_NONE;
		res.in_sequence      = ok;
		res.relative_seq     = rel;
		res.handshake_rtt_us = '0;
		if (cur.conn_state == tsst_pkg::ST_SYNACK_SENT && st_nxt == tsst_pkg::ST_ESTABLISHED) begin
			res.event_res        = tsst_pkg::EV_ESTABLISHED;
			res.handshake_rtt_us = item.timestamp_us[tsst_pkg::RTT_W-1:0] - cur.syn_time;
		end else if (cur.conn_state == tsst_pkg::ST_CLOSING && st_nxt == tsst_pkg::ST_CLOSED) begin
			res.event_res = tsst_pkg::EV_CLOSED;
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import tsst_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int EST_ITEMS   = 400;
	localparam int CLOSED_ITEMS = 227;
	localparam int CALM_ITEMS  = 80;

	// Holds its own copy of the session and the segment results still owed by the DUT.
	class seg_scoreboard;
		bit          seen_first;
		bit          client_side;
		conn_state_t conn_state;
		bit          closer_side;
		bit          has_base[2];
		logic [31:0] base_seq[2];
		logic [31:0] next_exp[2];
		logic [47:0] syn_time;
		result_t     pending_q[$];
		int          errors;

		function new();
			seen_first  = 1'b0;
			client_side = 1'b0;
			conn_state  = ST_NONE;
			closer_side = 1'b0;
			syn_time    = '0;
			errors      = 0;
			for (int i = 0; i < 2; i++) begin
				has_base[i] = 1'b0;
				base_seq[i] = '0;
				next_exp[i] = '0;
			end
		endfunction

		// Anchor a side's sequence space on its SYN or SYN|ACK.
		function void open_side(bit s, item_t seg);
			has_base[s] = 1'b1;
			base_seq[s] = seg.seq_num;
			next_exp[s] = 32'd1 + seg.segment_length;
		endfunction

		function void note_segment(item_t seg);
			logic [7:0]  fl;
			bit          s;
			bit          from_client;
			logic [31:0] rel;
			logic [47:0] elapsed;
			result_t     r;

			fl = seg.flags & FLAG_MASK;
			s  = seg.side;
			if (!seen_first) begin
				seen_first  = 1'b1;
				client_side = s;
			end
			from_client = (s == client_side);
			rel = seg.seq_num - base_seq[s];

			r.event_res        = EV_NONE;
			r.handshake_rtt_us = '0;
			r.in_sequence      = 1'b1;
			r.relative_seq     = rel;

			if (has_base[s]) begin
				if (next_exp[s] == rel)
					next_exp[s] = next_exp[s] + seg.segment_length;
				else
					r.in_sequence = 1'b0;
			end

			if (r.in_sequence) begin
				case (conn_state)
					ST_NONE: begin
						if (fl == TCP_SYN && from_client) begin
							conn_state = ST_SYN_SENT;
							syn_time   = seg.timestamp_us;
							open_side(s, seg);
						end
					end
					ST_SYN_SENT: begin
						if (fl == (TCP_SYN | TCP_ACK) && !from_client) begin
							conn_state = ST_SYNACK_SENT;
							open_side(s, seg);
						end
					end
					ST_SYNACK_SENT: begin
						if (fl == TCP_ACK && from_client) begin
							conn_state         = ST_ESTABLISHED;
							r.event_res        = EV_ESTABLISHED;
							elapsed            = seg.timestamp_us - syn_time;
							r.handshake_rtt_us = elapsed[31:0];
						end
					end
					ST_ESTABLISHED: begin
						if ((fl & TCP_FIN) != 0) begin
							conn_state  = ST_CLOSING;
							closer_side = s;
							next_exp[s] = next_exp[s] + 32'd1;
						end
					end
					ST_CLOSING: begin
						if ((fl & TCP_FIN) != 0 && closer_side != s) begin
							conn_state  = ST_CLOSED;
							r.event_res = EV_CLOSED;
							next_exp[s] = next_exp[s] + 32'd1;
						end
					end
					default: ;
				endcase
			end

			r.session_state = conn_state;
			pending_q.push_back(r);
		endfunction

		function void flag_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual %h", $time, got);
				return;
			end
			want = pending_q.pop_front();
			flag_field("session_state", 32'(want.session_state), 32'(got.session_state));
			flag_field("event_res", 32'(want.event_res), 32'(got.event_res));
			flag_field("in_sequence", 32'(want.in_sequence), 32'(got.in_sequence));
			flag_field("relative_seq", want.relative_seq, got.relative_seq);
			flag_field("handshake_rtt_us", want.handshake_rtt_us, got.handshake_rtt_us);
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;   // flags, seq_num, segment_length, timestamp_us
	logic         s_tuser;   // side
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;   // session_state, event_res, in_sequence, relative_seq,
	                         // handshake_rtt_us, zero

	seg_scoreboard sb;
	logic [47:0]   ts_clock;
	bit            tx_idle;
	bit            quiet_tail;
	int            cycle_count = 0;

	tcp_session_state_tracker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [15:0] rand_len();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 1460));
	endfunction

	// Builds a segment on the sender's expected sequence, or off it by a slip.
	function automatic item_t make_seg(input bit side, input logic [7:0] flags,
			input bit in_order, input logic [15:0] len);
		item_t       seg;
		logic [31:0] slip;
		logic [63:0] wide;
		slip = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(1, 4)) : $urandom;
		if (slip == '0)
			slip = 32'd1;
		ts_clock = ts_clock + 48'($urandom_range(1, 3000));
		if ($urandom_range(0, 31) == 0) begin
			wide = {$urandom, $urandom};
			ts_clock = wide[47:0];
		end
		seg.side           = side;
		seg.flags          = flags;
		seg.seq_num        = sb.base_seq[side] + sb.next_exp[side] + (in_order ? 32'd0 : slip);
		seg.segment_length = len;
		seg.timestamp_us   = ts_clock;
		return seg;
	endfunction

	task automatic send_seg(input item_t seg);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {seg.timestamp_us, seg.segment_length, seg.seq_num, seg.flags};
		s_tuser  <= seg.side;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_segment(seg);
	endtask

	// Result side: random stall bursts, one long hold-off to back the DUT up.
	initial begin
		result_t got;
		int      hold;
		int      seen;
		bit      rx_idle;
		hold    = 0;
		seen    = 0;
		rx_idle = 1'b1;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.session_state    = conn_state_t'(m_tdata[2:0]);
				got.event_res        = event_t'(m_tdata[4:3]);
				got.in_sequence      = m_tdata[5];
				got.relative_seq     = m_tdata[37:6];
				got.handshake_rtt_us = m_tdata[69:38];
				sb.check_result(got);
				seen++;
				if (seen == 150)
					hold = 80;
			end
			if ($urandom_range(0, 99) == 0)
				rx_idle = !rx_idle;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (rx_idle && !quiet_tail && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 13);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		item_t       seg;
		bit          c;
		bit          v;
		bit          f;
		logic [7:0]  fl;
		int          pick;

		sb = new();
		ts_clock   = '0;
		tx_idle    = 1'b1;
		quiet_tail = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		c = 1'($urandom_range(0, 1));
		v = !c;

		// opening segment fixes the client; all-ones fields, masked flags are not a SYN
		seg = make_seg(c, 8'hFF, 1'b1, 16'hFFFF);
		seg.seq_num      = 32'hFFFF_FFFF;
		seg.timestamp_us = 48'hFFFF_FFFF_FFFF;
		send_seg(seg);
		seg = make_seg(v, 8'h00, 1'b1, 16'h0000);
		seg.seq_num      = '0;
		seg.timestamp_us = '0;
		send_seg(seg);
		// SYN from the server, SYN|ACK from the client: no effect before the handshake
		seg = make_seg(v, TCP_SYN, 1'b1, rand_len());
		seg.seq_num = $urandom;
		send_seg(seg);
		seg = make_seg(c, TCP_SYN | TCP_ACK, 1'b1, rand_len());
		seg.seq_num = $urandom;
		send_seg(seg);
		// SYN with unused high flag bits set; base close to the top so sequences wrap
		seg = make_seg(c, TCP_SYN | 8'hE0, 1'b1, 16'd5);
		seg.seq_num      = 32'hFFFF_FFF0;
		seg.timestamp_us = 48'hFFFF_FFFF_FF00;
		send_seg(seg);
		// retransmitted SYN is now checked against the client's expected sequence
		seg = make_seg(c, TCP_SYN, 1'b0, 16'd0);
		seg.seq_num = 32'hFFFF_FFF0;
		send_seg(seg);
		send_seg(make_seg(c, TCP_ACK, 1'b1, 16'd3));
		seg = make_seg(v, TCP_SYN, 1'b1, rand_len());
		seg.seq_num = $urandom;
		send_seg(seg);
		seg = make_seg(v, TCP_SYN | TCP_ACK | TCP_RST, 1'b1, rand_len());
		seg.seq_num = $urandom;
		send_seg(seg);
		seg = make_seg(v, TCP_SYN | TCP_ACK, 1'b1, 16'd0);
		seg.seq_num = $urandom;
		send_seg(seg);
		send_seg(make_seg(v, TCP_ACK, 1'b0, rand_len()));
		send_seg(make_seg(c, TCP_ACK, 1'b0, 16'd0));
		send_seg(make_seg(c, TCP_FIN | TCP_ACK, 1'b1, 16'd2));
		// final ACK with a capture time earlier than the SYN: elapsed time wraps
		seg = make_seg(c, TCP_ACK, 1'b1, 16'd0);
		seg.timestamp_us = 48'h0000_0000_0010;
		send_seg(seg);
		send_seg(make_seg(v, TCP_RST, 1'b1, rand_len()));
		send_seg(make_seg(c, TCP_ACK | 8'h08, 1'b1, 16'hFFFF));
		send_seg(make_seg(v, TCP_FIN | TCP_ACK, 1'b0, 16'd0));

		// established traffic, FIN kept out of in-order segments
		for (int i = 0; i < EST_ITEMS; i++) begin
			if (i % 50 == 0)
				tx_idle = ($urandom_range(0, 3) != 0);
			f    = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				case ($urandom_range(0, 3))
					0: fl = TCP_ACK;
					1: fl = TCP_ACK | 8'h08;
					2: fl = TCP_ACK | TCP_RST;
					default: fl = 8'($urandom) & ~TCP_FIN;
				endcase
				send_seg(make_seg(f, fl, 1'b1, rand_len()));
			end else begin
				send_seg(make_seg(f, 8'($urandom), 1'b0, rand_len()));
			end
		end

		// teardown: first FIN, repeat FIN from the closer, stray FIN, an ACK, the peer's FIN, then a last FIN from the closer
		f = 1'($urandom_range(0, 1));
		send_seg(make_seg(f, TCP_FIN | TCP_ACK, 1'b1, rand_len()));
		send_seg(make_seg(f, TCP_FIN, 1'b1, 16'd0));
		send_seg(make_seg(!f, TCP_FIN | TCP_ACK, 1'b0, rand_len()));
		send_seg(make_seg(!f, TCP_ACK, 1'b1, rand_len()));
		send_seg(make_seg(!f, TCP_FIN | TCP_ACK, 1'b1, rand_len()));
		send_seg(make_seg(f, TCP_FIN, 1'b1, 16'd0));

		// closed: still sequence checked, state stays put
		for (int i = 0; i < CLOSED_ITEMS; i++) begin
			if (i == CLOSED_ITEMS - CALM_ITEMS) begin
				tx_idle    = 1'b0;
				quiet_tail = 1'b1;
			end else if (i % 50 == 0 && !quiet_tail) begin
				tx_idle = ($urandom_range(0, 3) != 0);
			end
			f = 1'($urandom_range(0, 1));
			send_seg(make_seg(f, 8'($urandom), ($urandom_range(0, 4) < 3), rand_len()));
		end
		s_tvalid <= 1'b0;

		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
